// ===== design/gps_pkg.sv =====
// ----------------------------------------------------------------------------
// gps_pkg
// Shared types and constants of the gait phase sequencer.
// ----------------------------------------------------------------------------
package gps_pkg;

    localparam int DT_W       = 21;
    localparam int DT_MAG_W   = DT_W - 1;
    localparam int RATE_W     = 24;
    localparam int DUR_W      = 24;
    localparam int CFG_W      = 24;
    localparam int CFG_ADDR_W = 1;
    localparam int PROD_FULL_W = DT_MAG_W + RATE_W;
    localparam int PROD_W     = 31;
    localparam int PHASE_W    = 33;
    localparam int TIMER_W    = 26;
    localparam int STATE_W    = 3;
    localparam int KIND_W     = 3;
    localparam int FAULT_W    = 2;
    localparam int S_TDATA_W  = 32;
    localparam int M_TDATA_W  = 48;

    localparam int QUEUE_DEPTH = 2;

    localparam logic [RATE_W-1:0]  PHASE_RATE_RESET     = 24'd42950;
    localparam logic [DUR_W-1:0]   PAUSE_DURATION_RESET = 24'd0;
    localparam logic [DT_MAG_W-1:0] ZERO_DT_US          = 20'd100;
    localparam logic [PROD_FULL_W-1:0] QUARTER_CYCLE    = PROD_FULL_W'(64'h4000_0000);
    localparam logic [PHASE_W-1:0] HALF_CYCLE           = 33'h0_8000_0000;
    localparam logic [PHASE_W:0]   FULL_CYCLE           = 34'h1_0000_0000;
    localparam logic [TIMER_W-1:0] TIMER_MAX            = 26'h3FF_FFFF;

    // configuration register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_PHASE_RATE     = 1'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_PAUSE_DURATION = 1'd1;

    // reported walk state codes
    localparam logic [STATE_W-1:0] WS_IDLE       = 3'd0;
    localparam logic [STATE_W-1:0] WS_START_MOVE = 3'd1;
    localparam logic [STATE_W-1:0] WS_START_STEP = 3'd2;
    localparam logic [STATE_W-1:0] WS_WALKING    = 3'd3;
    localparam logic [STATE_W-1:0] WS_KICK       = 3'd4;
    localparam logic [STATE_W-1:0] WS_STOP_STEP  = 3'd5;
    localparam logic [STATE_W-1:0] WS_STOP_MOVE  = 3'd6;
    localparam logic [STATE_W-1:0] WS_PAUSED     = 3'd7;

    // rebuild kinds
    localparam logic [KIND_W-1:0] RB_NONE       = 3'd0;
    localparam logic [KIND_W-1:0] RB_START_MOVE = 3'd1;
    localparam logic [KIND_W-1:0] RB_START_STEP = 3'd2;
    localparam logic [KIND_W-1:0] RB_NORMAL     = 3'd3;
    localparam logic [KIND_W-1:0] RB_KICK       = 3'd4;
    localparam logic [KIND_W-1:0] RB_STOP_STEP  = 3'd5;
    localparam logic [KIND_W-1:0] RB_STOP_MOVE  = 3'd6;

    // dt fault codes
    localparam logic [FAULT_W-1:0] FAULT_NONE = 2'd0;
    localparam logic [FAULT_W-1:0] FAULT_NEG  = 2'd1;
    localparam logic [FAULT_W-1:0] FAULT_LONG = 2'd2;

    // classified item as it waits between front and back
    typedef struct packed {
        logic                end_step;
        logic                cmd_still;
        logic                walkable_ok;
        logic                pause_request;
        logic                kick_left_request;
        logic                kick_right_request;
        logic                dt_neg;
        logic [DT_MAG_W-1:0] dt_mag;
        logic                prod_long;
        logic [PROD_W-1:0]   prod;
    } gps_item_t;

endpackage

// ===== design/gps_front.sv =====
// ----------------------------------------------------------------------------
// gps_front
// Accepts request items, classifies dt and forms the phase increment.
// ----------------------------------------------------------------------------
module gps_front (
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [gps_pkg::S_TDATA_W-1:0]      s_tdata,
    input  logic                               s_tuser,
    input  logic                               queue_full,
    input  logic [gps_pkg::RATE_W-1:0]         phase_rate,
    output logic                               push,
    output gps_pkg::gps_item_t                 item
);

    logic [gps_pkg::DT_W-1:0]        dt;
    logic [gps_pkg::DT_MAG_W-1:0]    dt_eff;
    logic [gps_pkg::PROD_FULL_W-1:0] prod_full;

    assign s_tready = !queue_full;
    assign push     = s_tvalid && !queue_full;
    assign dt       = s_tdata[gps_pkg::DT_W-1:0];

    // zero dt stands for the default tick length
    assign dt_eff    = (dt == '0) ? gps_pkg::ZERO_DT_US : dt[gps_pkg::DT_MAG_W-1:0];
    assign prod_full = gps_pkg::PROD_FULL_W'(dt_eff) * gps_pkg::PROD_FULL_W'(phase_rate);

    always_comb begin
        item                    = '0;
        item.end_step           = s_tuser;
        item.cmd_still          = s_tdata[gps_pkg::DT_W];
        item.walkable_ok        = s_tdata[gps_pkg::DT_W+1];
        item.pause_request      = s_tdata[gps_pkg::DT_W+2];
        item.kick_left_request  = s_tdata[gps_pkg::DT_W+3];
        item.kick_right_request = s_tdata[gps_pkg::DT_W+4];
        item.dt_neg             = dt[gps_pkg::DT_W-1];
        item.dt_mag             = dt[gps_pkg::DT_MAG_W-1:0];
        item.prod_long          = prod_full > gps_pkg::QUARTER_CYCLE;
        item.prod               = prod_full[gps_pkg::PROD_W-1:0];
    end

endmodule

// ===== design/gps_queue.sv =====
// ----------------------------------------------------------------------------
// gps_queue
// Short register queue between the classifying front and the sequencer.
// ----------------------------------------------------------------------------
module gps_queue #(
    parameter int DEPTH = gps_pkg::QUEUE_DEPTH
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               push,
    input  gps_pkg::gps_item_t push_item,
    output logic               full,
    input  logic               pop,
    output logic               not_empty,
    output gps_pkg::gps_item_t head_item
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    gps_pkg::gps_item_t entry_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign head_item = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// ===== design/gps_back.sv =====
// ----------------------------------------------------------------------------
// gps_back
// Walk state machine, phase accumulator, pause timer and result register.
// ----------------------------------------------------------------------------
module gps_back (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               in_valid,
    input  gps_pkg::gps_item_t                 in_item,
    output logic                               pop,
    input  logic [gps_pkg::DUR_W-1:0]          pause_duration,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [gps_pkg::M_TDATA_W-1:0]      m_tdata
);

    typedef enum logic [7:0] {
        MODE_IDLE       = 8'b0000_0001,
        MODE_START_MOVE = 8'b0000_0010,
        MODE_START_STEP = 8'b0000_0100,
        MODE_WALKING    = 8'b0000_1000,
        MODE_KICK       = 8'b0001_0000,
        MODE_STOP_STEP  = 8'b0010_0000,
        MODE_STOP_MOVE  = 8'b0100_0000,
        MODE_PAUSED     = 8'b1000_0000
    } mode_t;

    mode_t                           mode_reg, mode_next;
    logic [gps_pkg::PHASE_W-1:0]     phase_reg, phase_next;
    logic [gps_pkg::PHASE_W-1:0]     prev_phase_reg, prev_phase_next;
    logic                            left_reg, left_next;
    logic [gps_pkg::TIMER_W-1:0]     timer_reg, timer_next;
    logic                            pause_pend_reg, pause_pend_next;
    logic                            kick_l_reg, kick_l_next;
    logic                            kick_r_reg, kick_r_next;

    logic                            m_valid_reg;
    logic [gps_pkg::M_TDATA_W-1:0]   m_data_reg, m_data_next;

    logic                            done;
    logic                            half;
    logic                            mismatch;
    logic [gps_pkg::KIND_W-1:0]      kind;
    logic [gps_pkg::FAULT_W-1:0]     fault;
    logic [gps_pkg::STATE_W-1:0]     state_code;
    logic [gps_pkg::PHASE_W:0]       phase_sum;
    logic [gps_pkg::TIMER_W:0]       timer_sum;

    assign pop      = in_valid && (!m_valid_reg || m_tready);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    assign phase_sum = {1'b0, phase_reg} + (gps_pkg::PHASE_W+1)'(in_item.prod);
    assign timer_sum = {1'b0, timer_reg} + (gps_pkg::TIMER_W+1)'(in_item.dt_mag);

    always_comb begin
        mode_next       = mode_reg;
        phase_next      = phase_reg;
        prev_phase_next = prev_phase_reg;
        left_next       = left_reg;
        timer_next      = timer_reg;
        pause_pend_next = pause_pend_reg | in_item.pause_request;
        kick_l_next     = kick_l_reg | in_item.kick_left_request;
        kick_r_next     = kick_r_reg | in_item.kick_right_request;
        done            = 1'b0;
        half            = 1'b0;
        mismatch        = 1'b0;
        kind            = gps_pkg::RB_NONE;
        fault           = gps_pkg::FAULT_NONE;

        if (in_item.end_step) begin
            phase_next = (phase_reg < gps_pkg::HALF_CYCLE) ? gps_pkg::HALF_CYCLE : '0;
            done       = 1'b1;
        end else if (mode_reg == MODE_PAUSED) begin
            if (timer_reg > gps_pkg::TIMER_W'(pause_duration)) begin
                timer_next = '0;
                if (pause_pend_next) begin
                    pause_pend_next = 1'b0;
                    done            = 1'b1;
                end else begin
                    mode_next = MODE_WALKING;
                end
            end else begin
                if (in_item.dt_neg) begin
                    fault = gps_pkg::FAULT_NEG;
                end else if (timer_sum[gps_pkg::TIMER_W]) begin
                    timer_next = gps_pkg::TIMER_MAX;
                end else begin
                    timer_next = timer_sum[gps_pkg::TIMER_W-1:0];
                end
                done = 1'b1;
            end
        end else if (mode_reg == MODE_IDLE && (in_item.cmd_still || !in_item.walkable_ok)) begin
            done = 1'b1;
        end

        if (!done) begin
            if (in_item.dt_neg) begin
                fault = gps_pkg::FAULT_NEG;
            end else if (in_item.prod_long) begin
                fault = gps_pkg::FAULT_LONG;
            end else if (phase_sum > gps_pkg::FULL_CYCLE) begin
                phase_next = '0;
            end else begin
                phase_next = phase_sum[gps_pkg::PHASE_W-1:0];
            end

            half = (prev_phase_reg < gps_pkg::HALF_CYCLE && phase_next >= gps_pkg::HALF_CYCLE)
                || (prev_phase_reg > gps_pkg::HALF_CYCLE && phase_next < gps_pkg::HALF_CYCLE);

            // mode_next already holds walking when this tick leaves the pause
            case (mode_next)
                MODE_IDLE: begin
                    kind      = gps_pkg::RB_START_MOVE;
                    mode_next = MODE_START_MOVE;
                end
                MODE_START_MOVE: begin
                    if (half) begin
                        if (in_item.cmd_still) begin
                            mode_next = MODE_STOP_MOVE;
                            kind      = gps_pkg::RB_STOP_MOVE;
                        end else begin
                            mode_next = MODE_START_STEP;
                            kind      = gps_pkg::RB_START_STEP;
                        end
                    end
                end
                MODE_START_STEP: begin
                    if (half) begin
                        if (in_item.cmd_still) begin
                            mode_next = MODE_STOP_STEP;
                            kind      = gps_pkg::RB_STOP_STEP;
                        end else begin
                            mode_next = MODE_WALKING;
                            kind      = gps_pkg::RB_NORMAL;
                        end
                    end
                end
                MODE_WALKING: begin
                    if (half && pause_pend_next) begin
                        mode_next       = MODE_PAUSED;
                        pause_pend_next = 1'b0;
                        done            = 1'b1;
                    end else if (half && ((kick_l_next && !left_reg)
                                          || (kick_r_next && left_reg))) begin
                        kind        = gps_pkg::RB_KICK;
                        mode_next   = MODE_KICK;
                        kick_l_next = 1'b0;
                        kick_r_next = 1'b0;
                    end else if (half) begin
                        if (in_item.cmd_still) begin
                            mode_next = MODE_STOP_STEP;
                            kind      = gps_pkg::RB_STOP_STEP;
                        end else begin
                            kind = gps_pkg::RB_NORMAL;
                        end
                    end
                end
                MODE_KICK: begin
                    if (half) begin
                        mode_next = MODE_WALKING;
                        kind      = gps_pkg::RB_NORMAL;
                    end
                end
                MODE_STOP_STEP: begin
                    if (half) begin
                        mode_next = MODE_STOP_MOVE;
                        kind      = gps_pkg::RB_STOP_MOVE;
                    end
                end
                MODE_STOP_MOVE: begin
                    if (half) begin
                        mode_next = MODE_IDLE;
                        done      = 1'b1;
                    end
                end
                default: begin
                end
            endcase

            // every rebuild swaps the support foot
            if (kind != gps_pkg::RB_NONE) begin
                left_next = !left_reg;
            end

            if (!done) begin
                mismatch = (phase_next < gps_pkg::HALF_CYCLE && !left_next)
                        || (phase_next >= gps_pkg::HALF_CYCLE && left_next);
                if (!mismatch) begin
                    prev_phase_next = phase_next;
                end
            end
        end
    end

    always_comb begin
        case (mode_next)
            MODE_IDLE:       state_code = gps_pkg::WS_IDLE;
            MODE_START_MOVE: state_code = gps_pkg::WS_START_MOVE;
            MODE_START_STEP: state_code = gps_pkg::WS_START_STEP;
            MODE_WALKING:    state_code = gps_pkg::WS_WALKING;
            MODE_KICK:       state_code = gps_pkg::WS_KICK;
            MODE_STOP_STEP:  state_code = gps_pkg::WS_STOP_STEP;
            MODE_STOP_MOVE:  state_code = gps_pkg::WS_STOP_MOVE;
            MODE_PAUSED:     state_code = gps_pkg::WS_PAUSED;
            default:         state_code = gps_pkg::WS_IDLE;
        endcase
    end

    assign m_data_next = {4'b0, mismatch, fault, kind, half, left_next, phase_next, state_code};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg       <= MODE_IDLE;
            phase_reg      <= '0;
            prev_phase_reg <= '0;
            left_reg       <= 1'b0;
            timer_reg      <= '0;
            pause_pend_reg <= 1'b0;
            kick_l_reg     <= 1'b0;
            kick_r_reg     <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (pop) begin
                mode_reg       <= mode_next;
                phase_reg      <= phase_next;
                prev_phase_reg <= prev_phase_next;
                left_reg       <= left_next;
                timer_reg      <= timer_next;
                pause_pend_reg <= pause_pend_next;
                kick_l_reg     <= kick_l_next;
                kick_r_reg     <= kick_r_next;
                m_valid_reg    <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            m_data_reg <= m_data_next;
        end
    end

endmodule

// ===== design/gait_phase_sequencer.sv =====
// ----------------------------------------------------------------------------
// gait_phase_sequencer
// Gait phase and walk state sequencer for a legged walk controller.
// ----------------------------------------------------------------------------
// Requests enter on the s_ stream (one tick or end-step request each) and
// every request gives exactly one result on the m_ stream, in order.
// Registers phase_rate and pause_duration are written through cfg_we,
// cfg_addr and cfg_wdata; the user writes them only while the block is idle.
// The block does not enforce this. An accepted request passes through the
// queue to the result register, which drives m_tdata with m_tvalid high.
// Throughput: one request per cycle while m_tready is high. The front stage
// does the dt times rate multiply and writes a short queue; the back stage
// reads one queued request a cycle into the walk FSM and result register.
// When the receiver holds m_tready low the result register holds its data,
// the queue fills and s_tready drops once it is full; no request is lost.
// Reset (aresetn low at a clock edge) empties the queue and result register,
// returns the walk to idle with zero phase and right foot support, clears
// pending requests and the pause timer, and restores register defaults.
// ----------------------------------------------------------------------------
module gait_phase_sequencer #(
    parameter int QUEUE_DEPTH = gps_pkg::QUEUE_DEPTH
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    // config write port
    input  logic                               cfg_we,
    input  logic [gps_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  logic [gps_pkg::CFG_W-1:0]          cfg_wdata,
    // request stream
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // dt_us[20:0], cmd_still[21], walkable_ok[22], pause_request[23],
    // kick_left_request[24], kick_right_request[25], zero[31:26]
    input  logic [gps_pkg::S_TDATA_W-1:0]      s_tdata,
    // op[0]
    input  logic                               s_tuser,
    // result stream
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // walk_state[2:0], gait_phase[35:3], left_support[36], half_step_done[37],
    // rebuild_kind[40:38], dt_fault[42:41], support_mismatch[43], zero[47:44]
    output logic [gps_pkg::M_TDATA_W-1:0]      m_tdata
);

    logic [gps_pkg::RATE_W-1:0] phase_rate_reg;
    logic [gps_pkg::DUR_W-1:0]  pause_duration_reg;

    logic                       push;
    logic                       pop;
    logic                       queue_full;
    logic                       queue_not_empty;
    gps_pkg::gps_item_t         front_item;
    gps_pkg::gps_item_t         head_item;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_rate_reg     <= gps_pkg::PHASE_RATE_RESET;
            pause_duration_reg <= gps_pkg::PAUSE_DURATION_RESET;
        end else if (cfg_we) begin
            case (cfg_addr)
                gps_pkg::REG_PHASE_RATE: begin
                    phase_rate_reg <= cfg_wdata[gps_pkg::RATE_W-1:0];
                end
                gps_pkg::REG_PAUSE_DURATION: begin
                    pause_duration_reg <= cfg_wdata[gps_pkg::DUR_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    gps_front u_front (
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .queue_full (queue_full),
        .phase_rate (phase_rate_reg),
        .push       (push),
        .item       (front_item)
    );

    gps_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_item (front_item),
        .full      (queue_full),
        .pop       (pop),
        .not_empty (queue_not_empty),
        .head_item (head_item)
    );

    gps_back u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .in_valid       (queue_not_empty),
        .in_item        (head_item),
        .pop            (pop),
        .pause_duration (pause_duration_reg),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata)
    );

endmodule
